// ----- hdl/fbpa_pkg.sv -----
`default_nettype none
package fbpa_pkg;

	// fixed field widths
	localparam int SIZE_W  = 17;                // stride / block size width
	localparam int QUOT_W  = 9;                 // block index width from the count register
	localparam int REM_W   = SIZE_W + QUOT_W;   // offset width inside the storage
	localparam int STEP_W  = $clog2(QUOT_W);
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;
	localparam int CNT_W   = 9;
	localparam int AOUT_W  = 32;

	localparam int ALIGN_MAX = 12;

	localparam logic [CIDX_W-1:0] REG_BASE  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SIZE  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_ALIGN = 3'd2;
	localparam logic [CIDX_W-1:0] REG_COUNT = 3'd3;

	localparam logic [31:0]       RST_BASE  = 32'd0;
	localparam logic [SIZE_W-1:0] RST_SIZE  = 17'd64;
	localparam logic [3:0]        RST_ALIGN = 4'd3;
	localparam logic [8:0]        RST_COUNT = 9'd256;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_BAD_ADDR  = 2'd2,
		ST_NOT_BUSY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_POP,
		S_ADDR,
		S_DIV,
		S_BREAD,
		S_BCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] release_address;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] block_address;
		logic [8:0]  in_use_count;
		logic [8:0]  available_count;
		logic [8:0]  high_watermark;
		logic [31:0] failed_acquires;
	} rsp_t;

	typedef struct packed {
		logic [CIDX_W-1:0]  index;
		logic [CDATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic set_exh;
		logic set_bad;
		logic set_nb;
		logic div_load;
		logic div_step;
		logic pop;
		logic form_addr;
		logic release_blk;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic clr_last;
		logic is_rel;
		logic empty;
		logic bad;
		logic div_last;
		logic rem_zero;
		logic busy_bit;
	} stat_t;

endpackage
`default_nettype wire

// ----- hdl/fbpa_chan_if.sv -----
`default_nettype none
interface fbpa_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/fbpa_ram.sv -----
`default_nettype none
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/fbpa_ctrl.sv -----
`default_nettype none
module fbpa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fbpa_pkg::stat_t st,
	input  wire logic            req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output fbpa_pkg::cmd_t       cmd
);
	fbpa_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbpa_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			fbpa_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clr_last) begin
					state_d = fbpa_pkg::S_IDLE;
				end
			end
			fbpa_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = fbpa_pkg::S_CHECK;
				end
			end
			fbpa_pkg::S_CHECK: begin
				if (!st.is_rel) begin
					if (st.empty) begin
						cmd.set_exh = 1'b1;
						state_d     = fbpa_pkg::S_DONE;
					end else begin
						state_d = fbpa_pkg::S_POP;
					end
				end else if (st.bad) begin
					cmd.set_bad = 1'b1;
					state_d     = fbpa_pkg::S_DONE;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = fbpa_pkg::S_DIV;
				end
			end
			fbpa_pkg::S_POP: begin
				cmd.pop = 1'b1;
				state_d = fbpa_pkg::S_ADDR;
			end
			fbpa_pkg::S_ADDR: begin
				cmd.form_addr = 1'b1;
				state_d       = fbpa_pkg::S_DONE;
			end
			fbpa_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = fbpa_pkg::S_BREAD;
				end
			end
			fbpa_pkg::S_BREAD: begin
				if (!st.rem_zero) begin
					cmd.set_bad = 1'b1;
					state_d     = fbpa_pkg::S_DONE;
				end else begin
					state_d = fbpa_pkg::S_BCHK;
				end
			end
			fbpa_pkg::S_BCHK: begin
				if (st.busy_bit) begin
					cmd.release_blk = 1'b1;
				end else begin
					cmd.set_nb = 1'b1;
				end
				state_d = fbpa_pkg::S_DONE;
			end
			fbpa_pkg::S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = fbpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fbpa_pkg::S_CLEAR;
			end
		endcase
		if (st.cfg_hit) begin
			state_d = fbpa_pkg::S_CLEAR;
		end
	end

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten before taken");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && !st.cfg_hit |=> out_valid_q)
		else $error("loaded result not shown");
endmodule
`default_nettype wire

// ----- hdl/fbpa_dp.sv -----
`default_nettype none
module fbpa_dp #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fbpa_pkg::cmd_t  cmd,
	output fbpa_pkg::stat_t      st,
	input  wire logic            cfg_we,
	input  wire fbpa_pkg::cfg_t  cfg_in,
	input  wire fbpa_pkg::req_t  req_in,
	output fbpa_pkg::rsp_t       rsp_out
);
	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int AMW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
	localparam int SW  = fbpa_pkg::SIZE_W;
	localparam int QW  = fbpa_pkg::QUOT_W;
	localparam int RW  = fbpa_pkg::REM_W;

	logic [31:0]   base_q;
	logic [SW-1:0] size_q;
	logic [3:0]    align_q;
	logic [8:0]    count_q;

	// stride needs one bit above the size: a large size rounds up to 2^SW
	logic [SW:0]   stride_q;
	logic [RW-1:0] storage_q;
	logic [CW-1:0] cnt_q;

	logic [CW-1:0] depth_q, low_q, peak_q;
	logic [31:0]   refused_q;
	logic [IW-1:0] clr_q;

	fbpa_pkg::req_t    req_q;
	fbpa_pkg::status_t status_q;
	logic [31:0]       addr_q;
	logic [RW-1:0]     prod_q;
	logic [RW-1:0]     rem_q;
	logic [QW-1:0]     quot_q;
	logic [fbpa_pkg::STEP_W-1:0] step_q;
	fbpa_pkg::rsp_t    out_q;

	logic          stk_we, bsy_we, bsy_wdata;
	logic [IW-1:0] stk_rdata, bsy_waddr, pop_idx;
	logic          bsy_rdata;

	// effective configuration
	logic [SW-1:0] sz;
	logic [3:0]    al;
	logic [12:0]   amask;
	logic [SW:0]   rounded;
	logic [SW:0]   stride_d;
	logic [8:0]    bc;
	logic [CW-1:0] cnt_d;
	logic [SW+CW:0] storage_full;

	always_comb begin
		sz       = (size_q == '0) ? SW'(1) : size_q;
		al       = (align_q > 4'(fbpa_pkg::ALIGN_MAX)) ? 4'(fbpa_pkg::ALIGN_MAX) : align_q;
		amask    = 13'((14'd1 << al) - 14'd1);
		rounded  = ({1'b0, sz} + (SW+1)'(amask)) & ~((SW+1)'(amask));
		stride_d = rounded;
		bc       = (count_q == '0) ? 9'd1 : count_q;
		cnt_d    = (32'(bc) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(bc);
	end

	assign storage_full = stride_q * cnt_q;

	// release address checks
	logic [31:0] a_m, b_m, off;
	logic        below, beyond;
	assign a_m    = 32'(req_q.release_address[AMW-1:0]);
	assign b_m    = 32'(base_q[AMW-1:0]);
	assign below  = a_m < b_m;
	assign off    = a_m - b_m;
	assign beyond = off >= 32'(storage_q);

	// divider trial
	logic [RW-1:0] trial;
	assign trial = RW'(stride_q) << step_q;

	// pop index: entries below the lowest depth seen are still in initial order
	assign pop_idx = (depth_q <= low_q) ? IW'(cnt_q - depth_q) : stk_rdata;

	logic [SW+IW:0] prod_full;
	assign prod_full = stride_q * pop_idx;

	logic [32:0] addr_sum;
	assign addr_sum = {1'b0, base_q} + 33'(prod_q);

	logic [CW-1:0] busy_next;
	assign busy_next = cnt_q - depth_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= fbpa_pkg::RST_BASE;
			size_q    <= fbpa_pkg::RST_SIZE;
			align_q   <= fbpa_pkg::RST_ALIGN;
			count_q   <= fbpa_pkg::RST_COUNT;
			depth_q   <= '0;
			low_q     <= '0;
			peak_q    <= '0;
			refused_q <= '0;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_in.index)
					fbpa_pkg::REG_BASE:  base_q  <= cfg_in.data;
					fbpa_pkg::REG_SIZE:  size_q  <= cfg_in.data[SW-1:0];
					fbpa_pkg::REG_ALIGN: align_q <= cfg_in.data[3:0];
					fbpa_pkg::REG_COUNT: count_q <= cfg_in.data[8:0];
					default: ;
				endcase
			end
			if (st.cfg_hit) begin
				clr_q <= '0;
			end else if (cmd.clear) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.clear) begin
				depth_q   <= cnt_q;
				low_q     <= cnt_q;
				peak_q    <= '0;
				refused_q <= '0;
			end
			if (cmd.set_exh && refused_q != '1) begin
				refused_q <= refused_q + 32'd1;
			end
			if (cmd.pop) begin
				depth_q <= depth_q - CW'(1);
				if (depth_q <= low_q) begin
					low_q <= depth_q - CW'(1);
				end
				if (busy_next > peak_q) begin
					peak_q <= busy_next;
				end
			end
			if (cmd.release_blk) begin
				depth_q <= depth_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		stride_q  <= stride_d;
		cnt_q     <= cnt_d;
		storage_q <= RW'(storage_full);
		if (cmd.capture) begin
			req_q    <= req_in;
			status_q <= fbpa_pkg::ST_OK;
			addr_q   <= '0;
		end
		if (cmd.set_exh) status_q <= fbpa_pkg::ST_EXHAUSTED;
		if (cmd.set_bad) status_q <= fbpa_pkg::ST_BAD_ADDR;
		if (cmd.set_nb)  status_q <= fbpa_pkg::ST_NOT_BUSY;
		if (cmd.div_load) begin
			rem_q  <= off[RW-1:0];
			quot_q <= '0;
			step_q <= fbpa_pkg::STEP_W'(QW - 1);
		end else if (cmd.div_step) begin
			if (rem_q >= trial) begin
				rem_q          <= rem_q - trial;
				quot_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 1'b1;
		end
		if (cmd.pop) begin
			prod_q <= RW'(prod_full);
		end
		if (cmd.form_addr) begin
			addr_q <= 32'(addr_sum[AMW-1:0]);
		end
		if (cmd.load_out) begin
			out_q.status          <= status_q;
			out_q.block_address   <= addr_q;
			out_q.in_use_count    <= 9'(cnt_q - depth_q);
			out_q.available_count <= 9'(depth_q);
			out_q.high_watermark  <= 9'(peak_q);
			out_q.failed_acquires <= refused_q;
		end
	end

	assign rsp_out = out_q;

	// busy flag port: clearing sweep, pop marks busy, release clears
	always_comb begin
		bsy_we    = 1'b0;
		bsy_waddr = clr_q;
		bsy_wdata = 1'b0;
		priority if (cmd.clear) begin
			bsy_we = 1'b1;
		end else if (cmd.pop) begin
			bsy_we    = 1'b1;
			bsy_waddr = pop_idx;
			bsy_wdata = 1'b1;
		end else if (cmd.release_blk) begin
			bsy_we    = 1'b1;
			bsy_waddr = IW'(quot_q);
		end else begin
			bsy_we = 1'b0;
		end
	end

	assign stk_we = cmd.release_blk;

	fbpa_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (IW'(depth_q)),
		.wdata (IW'(quot_q)),
		.raddr (IW'(depth_q - CW'(1))),
		.rdata (stk_rdata)
	);

	fbpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_busy (
		.clk   (clk),
		.we    (bsy_we),
		.waddr (bsy_waddr),
		.wdata (bsy_wdata),
		.raddr (IW'(quot_q)),
		.rdata (bsy_rdata)
	);

	always_comb begin
		st.cfg_hit  = cfg_we && (cfg_in.index <= fbpa_pkg::REG_COUNT);
		st.clr_last = (clr_q == IW'(MAX_BLOCKS - 1));
		st.is_rel   = (req_q.cmd == fbpa_pkg::CMD_RELEASE);
		st.empty    = (depth_q == '0);
		st.bad      = below || beyond;
		st.div_last = (step_q == '0);
		st.rem_zero = (rem_q == '0);
		st.busy_bit = bsy_rdata;
	end

	a_depth_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |-> depth_q <= cnt_q)
		else $error("stack depth above block count");

	a_low_depth: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |-> low_q <= depth_q)
		else $error("low mark above stack depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop from empty free stack");
endmodule
`default_nettype wire

// ----- hdl/fixed_block_pool_allocator_unit.sv -----
// result: after a request is taken the sequencer runs check and done when refused at the first
// check; check, pop, address and done for a granted acquire; check, divider steps, remainder
// check, busy check and done for a release. One request in flight; done waits out output stalls
// release time is set by the 9-step restoring divider that turns the offset into a block index
// reset and every write to one of the four pool registers start a clearing pass over the
// busy-flag memory; requests are held off until it ends, configuration is always taken
`default_nettype none
module fixed_block_pool_allocator_unit #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	fbpa_chan_if.sink   req,
	fbpa_chan_if.source rsp,
	fbpa_chan_if.sink   cfg
);
	fbpa_pkg::cmd_t  cmd;
	fbpa_pkg::stat_t st;
	logic            cfg_we;

	// configuration port never stalls
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// sequencer: clear sweep, request decode, divider stepping, result hand-off
	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (st),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// config registers, free stack, busy flags, counters, divider and result register
	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.st      (st),
		.cfg_we  (cfg_we),
		.cfg_in  (cfg.payload),
		.req_in  (req.payload),
		.rsp_out (rsp.payload)
	);
endmodule
`default_nettype wire

// ----- sim/fixed_block_pool_allocator_unit_tb.sv -----
`default_nettype none
module fixed_block_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  POOL_MAX   = 256;
	localparam int  DRAIN_WAIT = 20;      // longest request latency plus margin
	localparam int  RUN_LIMIT  = 400000;  // cycles before the watchdog gives up
	localparam int  PHASES     = 9;
	localparam int  PHASE_REQS = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fbpa_chan_if #(.payload_t(fbpa_pkg::req_t)) req_ch ();
	fbpa_chan_if #(.payload_t(fbpa_pkg::rsp_t)) rsp_ch ();
	fbpa_chan_if #(.payload_t(fbpa_pkg::cfg_t)) cfg_ch ();

	fixed_block_pool_allocator_unit #(
		.MAX_BLOCKS(POOL_MAX),
		.ADDR_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// pool shadow: registers, free stack, busy flags and counters
	// ---------------------------------------------------------------
	logic [31:0]     pool_base;
	logic [16:0]     size_reg;
	logic [3:0]      align_reg;
	logic [8:0]      count_reg;
	int unsigned     n_blocks;
	longint unsigned stride_b;
	longint unsigned span_b;
	logic [7:0]      free_lifo [POOL_MAX];
	int unsigned     lifo_depth;
	bit              blk_busy [POOL_MAX];
	logic [8:0]      n_busy, n_free, peak_busy;
	logic [31:0]     refused;

	fbpa_pkg::rsp_t expected_rsp [$];
	int   errors = 0;
	int   cyc = 0;
	int   rsp_seen = 0;

	// rebuild the pool after reset or a write to one of the four pool registers
	function automatic void pool_reinit();
		longint unsigned sz, amask;
		int unsigned al;
		sz    = (size_reg == 0) ? 1 : size_reg;
		al    = (align_reg > fbpa_pkg::ALIGN_MAX) ? fbpa_pkg::ALIGN_MAX : align_reg;
		amask = (64'd1 << al) - 1;
		n_blocks = (count_reg == 0) ? 1 : count_reg;
		if (n_blocks > POOL_MAX)
			n_blocks = POOL_MAX;
		stride_b = (sz + amask) & ~amask;
		span_b   = stride_b * n_blocks;
		// descending indices, block zero on top
		for (int i = 0; i < POOL_MAX; i++) begin
			free_lifo[i] = 8'(n_blocks - 1 - i);
			blk_busy[i]  = 1'b0;
		end
		lifo_depth = n_blocks;
		n_busy     = 9'd0;
		n_free     = 9'(n_blocks);
		peak_busy  = 9'd0;
		refused    = 32'd0;
	endfunction

	function automatic void pool_write_reg(fbpa_pkg::cfg_t c);
		case (c.index)
			fbpa_pkg::REG_BASE: begin
				pool_base = c.data;
			end
			fbpa_pkg::REG_SIZE: begin
				size_reg = c.data[16:0];
			end
			fbpa_pkg::REG_ALIGN: begin
				align_reg = c.data[3:0];
			end
			fbpa_pkg::REG_COUNT: begin
				count_reg = c.data[8:0];
			end
			default: begin
				return;  // unknown index leaves the pool untouched
			end
		endcase
		pool_reinit();
	endfunction

	// expected answer to one request, updating the shadow
	function automatic fbpa_pkg::rsp_t pool_serve(fbpa_pkg::req_t r);
		fbpa_pkg::rsp_t o;
		longint unsigned off, idx;
		logic [7:0] top;
		o = '0;
		o.status = fbpa_pkg::ST_OK;
		if (r.cmd == fbpa_pkg::CMD_ACQUIRE) begin
			if (lifo_depth == 0) begin
				o.status = fbpa_pkg::ST_EXHAUSTED;
				if (refused != 32'hFFFF_FFFF)
					refused++;
			end else begin
				lifo_depth--;
				top = free_lifo[lifo_depth];
				blk_busy[top] = 1'b1;
				n_busy++;
				n_free--;
				if (n_busy > peak_busy)
					peak_busy = n_busy;
				o.block_address = 32'(pool_base + top * stride_b);  // wraps at 32 bits
			end
		end else if (r.release_address < pool_base) begin
			o.status = fbpa_pkg::ST_BAD_ADDR;
		end else begin
			off = r.release_address - pool_base;
			if (off >= span_b || off % stride_b != 0) begin
				o.status = fbpa_pkg::ST_BAD_ADDR;
			end else begin
				idx = off / stride_b;
				if (!blk_busy[idx]) begin
					o.status = fbpa_pkg::ST_NOT_BUSY;
				end else begin
					blk_busy[idx] = 1'b0;
					free_lifo[lifo_depth] = 8'(idx);
					lifo_depth++;
					n_busy--;
					n_free++;
				end
			end
		end
		o.in_use_count    = n_busy;
		o.available_count = n_free;
		o.high_watermark  = peak_busy;
		o.failed_acquires = refused;
		return o;
	endfunction

	// address of block idx under the current setting
	function automatic logic [31:0] blk_addr(int unsigned idx);
		return 32'(pool_base + idx * stride_b);
	endfunction

	// ---------------------------------------------------------------
	// idling: ~30% gaps on both sides, none in a steady window
	// ---------------------------------------------------------------
	wire steady = (cyc >= 8000) && (cyc < 12000);

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > RUN_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// response side: random stalls, plus one long hold-off so requests back up
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	initial rsp_ch.ready = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && rsp_seen == 300) begin
			hold_done = 1'b1;
			hold_cnt  = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
		end
	end

	// response checker: field by field against the oldest expectation
	always @(posedge clk) begin
		fbpa_pkg::rsp_t want, got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			rsp_seen <= rsp_seen + 1;
			if (expected_rsp.size() == 0) begin
				$error("response transaction with nothing outstanding");
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.block_address !== want.block_address) begin
					$error("block_address: expected %h, got %h",
						want.block_address, got.block_address);
					errors++;
				end
				if (got.in_use_count !== want.in_use_count) begin
					$error("in_use_count: expected %0d, got %0d",
						want.in_use_count, got.in_use_count);
					errors++;
				end
				if (got.available_count !== want.available_count) begin
					$error("available_count: expected %0d, got %0d",
						want.available_count, got.available_count);
					errors++;
				end
				if (got.high_watermark !== want.high_watermark) begin
					$error("high_watermark: expected %0d, got %0d",
						want.high_watermark, got.high_watermark);
					errors++;
				end
				if (got.failed_acquires !== want.failed_acquires) begin
					$error("failed_acquires: expected %0d, got %0d",
						want.failed_acquires, got.failed_acquires);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// drivers: everything changes on the falling edge
	// ---------------------------------------------------------------
	// one request transaction; valid stays up into the next call unless it idles
	task automatic send_req(fbpa_pkg::req_t r, bit typed, fbpa_pkg::status_t t_st,
		logic [31:0] t_addr);
		fbpa_pkg::rsp_t want;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 30) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		want = pool_serve(r);
		if (typed) begin
			// hand-worked answer overrides the shadow for these fields
			want.status        = t_st;
			want.block_address = t_addr;
		end
		expected_rsp.insert(expected_rsp.size(), want);
	endtask

	// register write, only with the pool quiet
	task automatic send_cfg(logic [fbpa_pkg::CIDX_W-1:0] idx, logic [31:0] data);
		fbpa_pkg::cfg_t c;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		c.index = idx;
		c.data  = data;
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= c;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		pool_write_reg(c);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_pool(logic [31:0] b, logic [31:0] s, logic [31:0] a, logic [31:0] n);
		send_cfg(fbpa_pkg::REG_BASE, b);
		send_cfg(fbpa_pkg::REG_SIZE, s);
		send_cfg(fbpa_pkg::REG_ALIGN, a);
		send_cfg(fbpa_pkg::REG_COUNT, n);
	endtask

	// ---------------------------------------------------------------
	// directed table: register writes and requests in order
	// ---------------------------------------------------------------
	typedef struct {
		bit                          is_cfg;
		logic [fbpa_pkg::CIDX_W-1:0] idx;
		logic                        cmd;
		logic [31:0]                 data;
		bit                          typed;
		fbpa_pkg::status_t           st;
		logic [31:0]                 addr;
	} dir_row_t;

	dir_row_t dir_rows [26] = '{
		// reset setting: stride 64, 256 blocks, base 0
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'h40},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h40,
			1, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h40,
			1, fbpa_pkg::ST_NOT_BUSY,  32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h41,
			1, fbpa_pkg::ST_BAD_ADDR,  32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h4000,
			1, fbpa_pkg::ST_BAD_ADDR,  32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'hFFFF_FFFF,
			1, fbpa_pkg::ST_BAD_ADDR,  32'h0},
		// zero size, excess alignment, zero count: one 4 KiB block at the top
		'{1, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'hFFFF_FF00,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_SIZE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_ALIGN, fbpa_pkg::CMD_ACQUIRE, 32'hF,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_COUNT, fbpa_pkg::CMD_ACQUIRE, 32'h0,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'hFFFF_FF00},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_EXHAUSTED, 32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h0,
			1, fbpa_pkg::ST_BAD_ADDR,  32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'hFFFF_FF00,
			1, fbpa_pkg::ST_OK,        32'h0},
		// oversized count, 64 KiB blocks: second block wraps past 2^32
		'{1, fbpa_pkg::REG_COUNT, fbpa_pkg::CMD_ACQUIRE, 32'h1FF,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_SIZE,  fbpa_pkg::CMD_ACQUIRE, 32'h10000,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_ALIGN, fbpa_pkg::CMD_ACQUIRE, 32'h0,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'hFFFF_0000,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'hFFFF_0000},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_RELEASE, 32'h0,
			1, fbpa_pkg::ST_BAD_ADDR,  32'h0},
		// unknown register, then an unaligned base
		'{1, 3'd5,                fbpa_pkg::CMD_ACQUIRE, 32'h1234_5678,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{1, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h3,
			0, fbpa_pkg::ST_OK,        32'h0},
		'{0, fbpa_pkg::REG_BASE,  fbpa_pkg::CMD_ACQUIRE, 32'h0,
			1, fbpa_pkg::ST_OK,        32'h3}
	};

	// pick a release address: mostly real block addresses, some noise
	function automatic logic [31:0] pick_release();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 75)
			return blk_addr($urandom_range(n_blocks - 1));
		else if (roll < 85)
			return blk_addr($urandom_range(n_blocks - 1)) + $urandom_range(1, 3);
		else if (roll < 90)
			return 32'(pool_base + span_b);
		else
			return $urandom;
	endfunction

	initial begin
		fbpa_pkg::req_t r;
		logic [31:0] nb;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.payload = '0;
		pool_base = fbpa_pkg::RST_BASE;
		size_reg  = fbpa_pkg::RST_SIZE;
		align_reg = fbpa_pkg::RST_ALIGN;
		count_reg = fbpa_pkg::RST_COUNT;
		pool_reinit();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				send_cfg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				r.cmd = dir_rows[i].cmd;
				r.release_address = dir_rows[i].data;
				send_req(r, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].addr);
			end
		end

		// random phases, each under a fresh pool setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					set_pool(32'h0, 32'd1, 32'd0, 32'd256);
				end
				1: begin
					set_pool(32'hFFFF_FFFF, 32'h10000, 32'd12, 32'd1);
				end
				2: begin
					set_pool(32'h1000, 32'd1, 32'd12, 32'd4);
				end
				default: begin
					case ($urandom_range(3))
						0: nb = $urandom_range(1, 4);
						1: nb = $urandom_range(1, 16);
						2: nb = $urandom_range(0, 511);
						default: nb = 256;
					endcase
					set_pool($urandom, $urandom_range(0, 17'h1FFFF),
						$urandom_range(0, 15), nb);
				end
			endcase
			for (int k = 0; k < PHASE_REQS; k++) begin
				r.cmd = ($urandom_range(99) < 55) ? fbpa_pkg::CMD_ACQUIRE
					: fbpa_pkg::CMD_RELEASE;
				r.release_address = (r.cmd == fbpa_pkg::CMD_RELEASE) ? pick_release()
					: $urandom;
				send_req(r, 1'b0, fbpa_pkg::ST_OK, 32'h0);
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
